>>> rtl/core/poly_note_gate_matcher_top_macros.svh
// Assertion helpers shared by the matcher modules.
`ifndef POLY_NOTE_GATE_MATCHER_TOP_MACROS_SVH
`define POLY_NOTE_GATE_MATCHER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PNGM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by another one on the next edge.
`define PNGM_ASSERT_NEXT(lbl, pre, post, msg) \
    `PNGM_ASSERT(lbl, (pre) |=> (post), msg)

`endif

>>> rtl/core/pngm_pkg.sv
package pngm_pkg;

    localparam int NUM_CELLS_DEF    = 16;
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int FIFO_DEPTH_DEF   = 4;
    localparam int LEARN_DEPTH      = 16;
    localparam int MAX_RESULTS      = 16;
    localparam int NOTE_BASE        = 36;
    localparam int NOTE_CENTER      = 60;
    localparam logic [3:0] FRAME_END_CH = 4'd15;

    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LATCH_MASK     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD = 2'd1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_SET    = 2'd1,
        OP_ARM    = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_SET,
        CMD_ARM
    } cmd_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FRAME,
        B_LEARN,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               ch_ok;
        logic               gated;
        logic               eof;
        logic [3:0]         ch;
        logic signed [8:0]  note;
        logic [4:0]         cell_sel;
        logic               arm_ok;
        logic               seq;
    } cmd_t;

endpackage

>>> rtl/core/pngm_front.sv
module pngm_front #(
    parameter int NUM_CHANNELS = 16,
    parameter int NUM_CELLS    = 16
) (
    input  logic [pngm_pkg::IN_DATA_W-1:0] tdata,
    input  logic [pngm_pkg::IN_USER_W-1:0] tuser,
    input  logic signed [14:0]             gate_threshold,
    output pngm_pkg::cmd_t                 cmd,
    output logic                           keep
);
    import pngm_pkg::*;

    logic [3:0]         channel;
    logic               present;
    logic signed [15:0] pitch;
    logic signed [14:0] gate_level;
    logic signed [4:0]  cell_req;
    logic signed [7:0]  note_in;
    logic               seq_in;
    logic               cell_ok;
    logic [16:0]        mag;
    logic [16:0]        mag_rnd;
    logic [8:0]         steps;
    opcode_t            op;

    assign channel    = tdata[3:0];
    assign present    = tdata[4];
    assign pitch      = tdata[20:5];
    assign gate_level = tdata[35:21];
    assign cell_req   = tdata[40:36];
    assign note_in    = tdata[48:41];
    assign seq_in     = tdata[49];
    assign op         = opcode_t'(tuser);

    assign cell_ok = !cell_req[4] && ({27'd0, cell_req} < NUM_CELLS);

    // Round half away from zero: work on the magnitude, then reapply the sign.
    assign mag     = pitch[15] ? (17'd0 - {pitch[15], pitch}) : {1'b0, pitch};
    assign mag_rnd = mag + 17'd128;
    assign steps   = mag_rnd[16:8];

    always_comb
    begin
        cmd          = '0;
        cmd.kind     = CMD_SAMPLE;
        cmd.ch       = channel;
        cmd.ch_ok    = ({28'd0, channel} < NUM_CHANNELS);
        cmd.gated    = present && (gate_level >= gate_threshold);
        cmd.eof      = (channel == FRAME_END_CH);
        cmd.cell_sel = cell_req;
        cmd.arm_ok   = cell_ok;
        cmd.seq      = seq_in;
        keep         = 1'b0;
        case (op)
            OP_SAMPLE:
            begin
                cmd.note = pitch[15] ? (9'(NOTE_CENTER) - steps) : (9'(NOTE_CENTER) + steps);
                keep     = cmd.ch_ok || cmd.eof;
            end
            OP_SET:
            begin
                cmd.kind = CMD_SET;
                cmd.note = {note_in[7], note_in};
                keep     = cell_ok;
            end
            OP_ARM:
            begin
                cmd.kind = CMD_ARM;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/pngm_cmd_fifo.sv
`include "poly_note_gate_matcher_top_macros.svh"

module pngm_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pngm_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output pngm_pkg::cmd_t pop_data,
    output logic           empty
);
    import pngm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `PNGM_ASSERT(a_no_pop_empty, !(pop && empty), "pop from empty command queue")
    `PNGM_ASSERT(a_no_push_full, !(push && full), "push into full command queue")
    `PNGM_ASSERT(a_count_bound, count_reg <= (AW+1)'(DEPTH), "command queue count overflow")

endmodule

>>> rtl/core/pngm_back.sv
`include "poly_note_gate_matcher_top_macros.svh"

module pngm_back #(
    parameter int NUM_CELLS    = 16,
    parameter int NUM_CHANNELS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_avail,
    input  pngm_pkg::cmd_t                  cmd,
    output logic                            cmd_pop,
    input  logic [15:0]                     latch_mask,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pngm_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import pngm_pkg::*;

    localparam int CW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int NOUT = (NUM_CELLS < MAX_RESULTS) ? NUM_CELLS : MAX_RESULTS;
    localparam int EW   = (NOUT > 1) ? $clog2(NOUT) : 1;

    back_state_t state_reg, state_next;

    logic signed [7:0] nt_reg  [NUM_CELLS];
    logic              lg_reg  [NUM_CELLS];
    logic              pm_reg  [NUM_CELLS];
    logic              fm_reg  [NUM_CELLS];
    logic [4:0]        fmc_reg [NUM_CELLS];
    logic              pcg_reg [NUM_CHANNELS];
    logic [7:0]        pend_reg [LEARN_DEPTH];
    logic [4:0]        cnt_reg;
    logic [3:0]        k_reg;
    logic              armed_v_reg;
    logic [CW-1:0]     armed_reg;
    logic              seq_reg;
    logic              res_g_reg  [NOUT];
    logic              res_m_reg  [NOUT];
    logic [4:0]        res_ch_reg [NOUT];
    logic [EW-1:0]     e_reg;
    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    logic              asg_en;
    logic [CW-1:0]     asg_cell;
    logic signed [7:0] asg_note;
    logic              prev_gate;
    logic              out_load;
    logic              learn_done;
    logic              emit_done;
    logic [4:0]        armed_out;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign out_load  = (state_reg == B_EMIT) && (!m_tvalid_reg || m_tready);
    assign emit_done = out_load && (e_reg == EW'(NOUT-1));
    assign learn_done = ({1'b0, k_reg} == cnt_reg - 5'd1);
    assign armed_out = armed_v_reg ? 5'(armed_reg) : 5'h1f;

    always_comb
    begin
        prev_gate = 1'b0;
        for (int j = 0; j < NUM_CHANNELS; j++)
        begin
            if (5'(j) == {1'b0, cmd.ch})
            begin
                prev_gate = pcg_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        asg_en     = 1'b0;
        asg_cell   = cmd.cell_sel[CW-1:0];
        asg_note   = cmd.note[7:0];
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == CMD_SET)
                    begin
                        asg_en = 1'b1;
                    end
                    if (cmd.kind == CMD_SAMPLE && cmd.eof)
                    begin
                        state_next = B_FRAME;
                    end
                end
            end
            B_FRAME:
            begin
                state_next = (cnt_reg != 5'd0) ? B_LEARN : B_EMIT;
            end
            B_LEARN:
            begin
                asg_en   = armed_v_reg;
                asg_cell = armed_reg;
                asg_note = pend_reg[k_reg];
                if (learn_done)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Payload registers: results snapshot, learn queue and output beat.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && cmd_avail && cmd.kind == CMD_SAMPLE && cmd.ch_ok
            && cmd.gated && !prev_gate && armed_v_reg && cnt_reg < 5'(LEARN_DEPTH))
        begin
            pend_reg[cnt_reg[3:0]] <= cmd.note[7:0];
        end
        if (state_reg == B_FRAME)
        begin
            for (int i = 0; i < NOUT; i++)
            begin
                res_m_reg[i]  <= fm_reg[i];
                res_ch_reg[i] <= fmc_reg[i];
                if (latch_mask[i])
                begin
                    res_g_reg[i] <= (fm_reg[i] && !pm_reg[i]) ? !lg_reg[i] : lg_reg[i];
                end
                else
                begin
                    res_g_reg[i] <= fm_reg[i];
                end
            end
        end
        if (out_load)
        begin
            m_tdata_reg <= {armed_out, res_ch_reg[e_reg], res_m_reg[e_reg],
                            res_g_reg[e_reg], 4'(e_reg)};
            m_tlast_reg <= (e_reg == EW'(NOUT-1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CELLS; i++)
            begin
                nt_reg[i]  <= 8'(NOTE_BASE + i);
                lg_reg[i]  <= 1'b0;
                pm_reg[i]  <= 1'b0;
                fm_reg[i]  <= 1'b0;
                fmc_reg[i] <= 5'h1f;
            end
            for (int j = 0; j < NUM_CHANNELS; j++)
            begin
                pcg_reg[j] <= 1'b0;
            end
            cnt_reg      <= '0;
            k_reg        <= '0;
            armed_v_reg  <= 1'b0;
            armed_reg    <= '0;
            seq_reg      <= 1'b0;
            e_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == B_IDLE && cmd_avail)
            begin
                case (cmd.kind)
                    CMD_SAMPLE:
                    begin
                        if (cmd.ch_ok)
                        begin
                            if (cmd.gated)
                            begin
                                for (int i = 0; i < NUM_CELLS; i++)
                                begin
                                    if (!nt_reg[i][7] && {nt_reg[i][7], nt_reg[i]} == cmd.note)
                                    begin
                                        fm_reg[i]  <= 1'b1;
                                        fmc_reg[i] <= {1'b0, cmd.ch};
                                    end
                                end
                                if (!prev_gate && armed_v_reg && cnt_reg < 5'(LEARN_DEPTH))
                                begin
                                    cnt_reg <= cnt_reg + 5'd1;
                                end
                            end
                            for (int j = 0; j < NUM_CHANNELS; j++)
                            begin
                                if (5'(j) == {1'b0, cmd.ch})
                                begin
                                    pcg_reg[j] <= cmd.gated;
                                end
                            end
                        end
                    end
                    CMD_ARM:
                    begin
                        armed_v_reg <= cmd.arm_ok;
                        armed_reg   <= cmd.cell_sel[CW-1:0];
                        seq_reg     <= cmd.seq;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == B_FRAME)
            begin
                k_reg <= '0;
                for (int i = 0; i < NUM_CELLS; i++)
                begin
                    if (i < MAX_RESULTS && latch_mask[i % MAX_RESULTS] && fm_reg[i] && !pm_reg[i])
                    begin
                        lg_reg[i] <= !lg_reg[i];
                    end
                    pm_reg[i]  <= fm_reg[i];
                    fm_reg[i]  <= 1'b0;
                    fmc_reg[i] <= 5'h1f;
                end
            end

            if (state_reg == B_LEARN)
            begin
                if (armed_v_reg)
                begin
                    if (seq_reg && armed_reg != CW'(NUM_CELLS-1))
                    begin
                        armed_reg <= armed_reg + 1'b1;
                    end
                    else
                    begin
                        armed_v_reg <= 1'b0;
                    end
                end
                if (learn_done)
                begin
                    cnt_reg <= '0;
                end
                else
                begin
                    k_reg <= k_reg + 4'd1;
                end
            end

            // Assign a note: drop the duplicate elsewhere, reset the cell's history.
            if (asg_en)
            begin
                for (int i = 0; i < NUM_CELLS; i++)
                begin
                    if (!asg_note[7] && nt_reg[i] == asg_note)
                    begin
                        nt_reg[i] <= 8'hff;
                    end
                    if (CW'(i) == asg_cell)
                    begin
                        nt_reg[i]  <= asg_note;
                        lg_reg[i]  <= 1'b0;
                        pm_reg[i]  <= 1'b0;
                        fm_reg[i]  <= 1'b0;
                        fmc_reg[i] <= 5'h1f;
                    end
                end
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                e_reg        <= emit_done ? '0 : e_reg + 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    `PNGM_ASSERT(a_cnt_bound, cnt_reg <= 5'(LEARN_DEPTH), "learn queue count overflow")
    `PNGM_ASSERT(a_learn_nonempty, (state_reg == B_LEARN) |-> (cnt_reg != 5'd0), "learn pass with empty queue")
    `PNGM_ASSERT_NEXT(a_frame_clear, state_reg == B_FRAME, !fm_reg[0] && fmc_reg[0] == 5'h1f, "frame match not cleared after frame end")

endmodule

>>> rtl/core/poly_note_gate_matcher_top.sv
// Channel   Dir  Handshake                  Payload
// s_*       in   s_tvalid / s_tready        s_tdata, s_tuser (opcode)
// m_*       out  m_tvalid / m_tready        m_tdata, m_tlast (last result of frame)
// cfg_*     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// The execution unit takes samples and commands from the queue one at a time; a frame end adds
// a snapshot state, a learn pass over the queued learned notes (0 to 16), then an emit pass
// over the results (up to 16), which holds while the output is stalled.
// A command queue of FIFO_DEPTH entries (4 by default) lets the input keep accepting while results drain.
// rst_n clears control and cell state asynchronously; payload registers are not reset; no clearing pass is needed.
// cfg_ready is always high.
module poly_note_gate_matcher_top #(
    parameter int NUM_CELLS    = pngm_pkg::NUM_CELLS_DEF,
    parameter int NUM_CHANNELS = pngm_pkg::NUM_CHANNELS_DEF,
    parameter int FIFO_DEPTH   = pngm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // channel[3:0] present[4] pitch[20:5] gate_level[35:21] cell_req[40:36]
    // note[48:41] sequential[49], zero fill above
    input  logic [pngm_pkg::IN_DATA_W-1:0]   s_tdata,
    // opcode[1:0]
    input  logic [pngm_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // cell_index[3:0] gate_out[4] source_match[5] matched_channel[10:6] armed_cell[15:11]
    output logic [pngm_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pngm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pngm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pngm_pkg::*;

    logic [15:0]        latch_mask_reg;
    logic signed [14:0] gate_threshold_reg;
    cmd_t               front_cmd;
    cmd_t               queue_cmd;
    logic               keep;
    logic               full;
    logic               empty;
    logic               pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_mask_reg     <= '0;
            gate_threshold_reg <= 15'sd1000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LATCH_MASK:     latch_mask_reg     <= cfg_data;
                REG_GATE_THRESHOLD: gate_threshold_reg <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    pngm_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_CELLS    (NUM_CELLS)
    ) u_front (
        .tdata          (s_tdata),
        .tuser          (s_tuser),
        .gate_threshold (gate_threshold_reg),
        .cmd            (front_cmd),
        .keep           (keep)
    );

    pngm_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && !full && keep),
        .push_data (front_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (queue_cmd),
        .empty     (empty)
    );

    pngm_back #(
        .NUM_CELLS    (NUM_CELLS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_avail  (!empty),
        .cmd        (queue_cmd),
        .cmd_pop    (pop),
        .latch_mask (latch_mask_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
